// ===== hw/rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the serial bit sampler with resync.
// ----------------------------------------------------------------------------
`default_nettype none

package sbs_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitPosW    = 3;
  localparam int unsigned DivW       = 10;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] RegBitPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStartLoad  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegResyncLoad = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFrameBytes = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLineInvert = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPrescale   = 3'd5;

  localparam logic [2:0] PreDiv1    = 3'd0;
  localparam logic [2:0] PreDiv8    = 3'd1;
  localparam logic [2:0] PreDiv64   = 3'd2;
  localparam logic [2:0] PreDiv256  = 3'd3;
  localparam logic [2:0] PreDiv1024 = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0] bit_period;
    logic [ByteW-1:0] start_load;
    logic [ByteW-1:0] resync_load;
    logic [ByteW-1:0] frame_bytes;
    logic             line_invert;
    logic [2:0]       prescale_select;
  } cfg_t;

  // one classified line sample
  typedef struct packed {
    logic level;
    logic prev_level;
    logic tick;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [DivW-1:0] divider_limit(input logic [2:0] sel);
    logic [DivW-1:0] lim;
    unique case (sel)
      PreDiv8:    lim = 10'd7;
      PreDiv64:   lim = 10'd63;
      PreDiv256:  lim = 10'd255;
      PreDiv1024: lim = 10'd1023;
      default:    lim = 10'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_bit_sampler_with_resync_unit.sv =====
// With the queue empty, a byte is presented after its last bit's item is accepted and passes
// through the queue entry and then the bit engine's output register.
// Throughput: one item per cycle through the classifier and bit engine when not stalled.
// A four-entry queue between them absorbs output stall; input stalls only when it fills.
// Reset (rst_ni low, asynchronous): idle, timer and prescaler cleared, config at defaults.
// ----------------------------------------------------------------------------
// serial_bit_sampler_with_resync_unit
// Serial line sampler with edge resync, assembling LSB-first bytes per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bit_sampler_with_resync_unit #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sbs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          line_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [sbs_pkg::ByteW-1:0]          data_byte_o,
  output logic [sbs_pkg::ByteW-1:0]          byte_index_o,
  output logic                               frame_end_o
);
  import sbs_pkg::*;

  cfg_t         cfg_q, cfg_d;
  item_t        push_item, pop_item;
  logic         push, pop;
  fifo_status_t q_status;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBitPeriod:  cfg_d.bit_period      = cfg_data_i;
        RegStartLoad:  cfg_d.start_load      = cfg_data_i;
        RegResyncLoad: cfg_d.resync_load     = cfg_data_i;
        RegFrameBytes: cfg_d.frame_bytes     = cfg_data_i;
        RegLineInvert: cfg_d.line_invert     = cfg_data_i[0];
        RegPrescale:   cfg_d.prescale_select = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period      <= 8'd128;
      cfg_q.start_load      <= 8'd64;
      cfg_q.resync_load     <= 8'd64;
      cfg_q.frame_bytes     <= 8'd251;
      cfg_q.line_invert     <= 1'b0;
      cfg_q.prescale_select <= PreDiv1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .line_level_i (line_level_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (push_item)
  );

  sbs_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_item),
    .pop_i    (pop),
    .rdata_o  (pop_item),
    .status_o (q_status)
  );

  sbs_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (pop_item),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .frame_end_o  (frame_end_o)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_no_pop_on_held_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !pop)
    else $error("bit engine advanced while output item held");

  a_out_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop))
    else $error("output item appeared without a queue pop");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sbs_fifo.sv =====
// ----------------------------------------------------------------------------
// sbs_fifo
// Short register queue between the sample classifier and the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_fifo #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 pop_i,
  output logic [WIDTH-1:0]          rdata_o,
  output sbs_pkg::fifo_status_t     status_o
);
  import sbs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/sbs_front.sv =====
// ----------------------------------------------------------------------------
// sbs_front
// Accepts line samples, applies inversion and the prescaler, tags each item.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sbs_pkg::cfg_t        cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 line_level_i,
  input  wire sbs_pkg::fifo_status_t q_status_i,
  output logic                      push_o,
  output sbs_pkg::item_t            item_o
);
  import sbs_pkg::*;

  logic [DivW-1:0] div_q, div_d;
  logic            prev_q, prev_d;
  logic            level;
  logic            tick;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;
  assign level      = line_level_i ^ cfg_i.line_invert;
  assign tick       = (div_q >= divider_limit(cfg_i.prescale_select));

  always_comb begin
    div_d  = div_q;
    prev_d = prev_q;
    if (push_o) begin
      div_d  = tick ? '0 : div_q + 1'b1;
      prev_d = level;
    end
  end

  assign item_o.level      = level;
  assign item_o.prev_level = prev_q;
  assign item_o.tick       = tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      prev_q <= 1'b1;
    end else begin
      div_q  <= div_d;
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbs_back.sv =====
// ----------------------------------------------------------------------------
// sbs_back
// Bit engine: frame start, bit timer, resync, byte assembly, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbs_back #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sbs_pkg::cfg_t         cfg_i,
  input  wire sbs_pkg::item_t        item_i,
  input  wire sbs_pkg::fifo_status_t q_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [sbs_pkg::ByteW-1:0]  data_byte_o,
  output logic [sbs_pkg::ByteW-1:0]  byte_index_o,
  output logic                       frame_end_o
);
  import sbs_pkg::*;

  localparam int unsigned CmpW = (TIMER_BITS > ByteW) ? TIMER_BITS : ByteW;

  logic                  active_q, active_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic                  last_q, last_d;
  logic [ByteW-1:0]      shift_q, shift_d;
  logic [BitPosW-1:0]    pos_q, pos_d;
  logic [ByteW-1:0]      count_q, count_d;

  logic                  out_valid_q, out_valid_d;
  logic [ByteW-1:0]      out_byte_q, out_byte_d;
  logic [ByteW-1:0]      out_index_q, out_index_d;
  logic                  out_end_q, out_end_d;

  logic                  at_period;
  logic [ByteW-1:0]      shift_new;
  logic [ByteW-1:0]      total;
  logic                  is_last;

  assign pop_o     = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign at_period = (CmpW'(timer_q) >= CmpW'(cfg_i.bit_period));
  assign shift_new = shift_q | (ByteW'(item_i.level) << pos_q);
  assign total     = (cfg_i.frame_bytes == '0) ? ByteW'(1) : cfg_i.frame_bytes;
  assign is_last   = ({1'b0, count_q} + 9'd1) >= {1'b0, total};

  always_comb begin
    active_d    = active_q;
    timer_d     = timer_q;
    last_d      = last_q;
    shift_d     = shift_q;
    pos_d       = pos_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_index_d = out_index_q;
    out_end_d   = out_end_q;
    if (pop_o) begin
      if (!active_q) begin
        if (!item_i.level && !item_i.prev_level) begin
          active_d = 1'b1;
          timer_d  = TIMER_BITS'(cfg_i.start_load);
          last_d   = 1'b0;
          shift_d  = '0;
          pos_d    = '0;
          count_d  = '0;
        end
      end else if (at_period) begin
        timer_d = '0;
        last_d  = item_i.level;
        if (pos_q == BitPosW'(ByteW - 1)) begin
          out_valid_d = 1'b1;
          out_byte_d  = shift_new;
          out_index_d = count_q;
          out_end_d   = is_last;
          count_d     = count_q + 1'b1;
          shift_d     = '0;
          pos_d       = '0;
          if (is_last) begin
            active_d = 1'b0;
          end
        end else begin
          shift_d = shift_new;
          pos_d   = pos_q + 1'b1;
        end
      end else if (item_i.level != last_q && item_i.level == item_i.prev_level) begin
        timer_d = TIMER_BITS'(cfg_i.resync_load);
        last_d  = item_i.level;
      end else if (item_i.tick) begin
        timer_d = timer_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      timer_q     <= '0;
      last_q      <= 1'b0;
      shift_q     <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      timer_q     <= timer_d;
      last_q      <= last_d;
      shift_q     <= shift_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_index_q <= out_index_d;
    out_end_q   <= out_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_byte_q;
  assign byte_index_o = out_index_q;
  assign frame_end_o  = out_end_q;

endmodule

`default_nettype wire
